@@ design/ssph_pkg.sv @@
// ----------------------------------------------------------------------------
// ssph_pkg
// Shared types, register codes and helpers for the swept sphere / plane core.
// ----------------------------------------------------------------------------
package ssph_pkg;

    localparam int DW    = 52;   // signed distance width, Q.30
    localparam int QW    = 54;   // divider remainder / divisor width
    localparam int TBITS = 16;   // quotient fraction bits
    localparam int PW    = 68;   // normal * distance product width

    localparam logic [7:0] CFG_NORMAL_X     = 8'd0;
    localparam logic [7:0] CFG_NORMAL_Y     = 8'd1;
    localparam logic [7:0] CFG_NORMAL_Z     = 8'd2;
    localparam logic [7:0] CFG_PLANE_OFFSET = 8'd3;

    typedef struct packed {
        logic [2:0][15:0] n;
        logic [31:0]      off;
    } t_cfg;

    typedef struct packed {
        logic [2:0][31:0] s;
        logic [2:0][31:0] e;
        logic [30:0]      r;
    } t_item;

    typedef struct packed {
        t_item               item;
        logic                hit;
        logic                touch;
        logic                clamp;
        logic [QW-1:0]       rem;
        logic [QW-1:0]       den;
        logic [TBITS-1:0]    q;
        logic [2:0][PW-1:0]  tprod;
    } t_mid;

    function automatic logic [31:0] sat32(input logic signed [40:0] v);
        logic [31:0] res;
        if (v > 41'sd2147483647)
            res = 32'h7FFF_FFFF;
        else if (v < -41'sd2147483648)
            res = 32'h8000_0000;
        else
            res = v[31:0];
        return res;
    endfunction

endpackage

@@ design/swept_sphere_plane_hit_core.sv @@
// ----------------------------------------------------------------------------
// swept_sphere_plane_hit_core
// Swept sphere against a configured plane: hit flag, time and contact point.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carries one query (segment start, end and
// sphere radius, Q15.16). Output channel: o_valid / i_stall carries one result
// per query, in order. A transaction moves on an edge with valid high and
// stall low.
// Configuration: i_cfg_valid / o_cfg_ready (always ready) with i_cfg_index and
// i_cfg_data writes the normal (Q1.14) and plane offset (Q15.16). Unknown
// indexes are dropped. Write only while no query is in flight.
// The pipeline has 21 register stages: three front stages, sixteen divider
// stages (one quotient bit each) and two back stages, the last being the
// output register. It takes one query per cycle while the output is not
// stalled; the divider chain sets the depth.
// Reset (synchronous, active low) empties the pipeline and loads the normal
// (0, 0, 1.0) with offset 0. When the receiver stalls while a result is
// shown, the whole pipeline holds and o_stall is raised, so nothing is lost.
// ----------------------------------------------------------------------------
module swept_sphere_plane_hit_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_start_x,
    input  logic signed [31:0] i_start_y,
    input  logic signed [31:0] i_start_z,
    input  logic signed [31:0] i_end_x,
    input  logic signed [31:0] i_end_y,
    input  logic signed [31:0] i_end_z,
    input  logic [30:0]        i_sphere_radius,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_hit,
    output logic [16:0]        o_hit_time,
    output logic signed [31:0] o_contact_x,
    output logic signed [31:0] o_contact_y,
    output logic signed [31:0] o_contact_z,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import ssph_pkg::*;

    t_cfg             r_cfg;
    t_item            w_item;
    logic             w_en;
    logic             w_fv, w_dv;
    t_mid             w_fm, w_dm;
    logic [2:0][31:0] w_pt;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.n   <= {16'd16384, 16'd0, 16'd0};
            r_cfg.off <= 32'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_NORMAL_X:     r_cfg.n[0] <= i_cfg_data[15:0];
                CFG_NORMAL_Y:     r_cfg.n[1] <= i_cfg_data[15:0];
                CFG_NORMAL_Z:     r_cfg.n[2] <= i_cfg_data[15:0];
                CFG_PLANE_OFFSET: r_cfg.off  <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // hold everything while the shown result is not taken
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    assign w_item.s = {i_start_z, i_start_y, i_start_x};
    assign w_item.e = {i_end_z, i_end_y, i_end_x};
    assign w_item.r = i_sphere_radius;

    ssph_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_item  (w_item),
        .i_cfg   (r_cfg),
        .o_valid (w_fv),
        .o_mid   (w_fm)
    );

    ssph_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fv),
        .i_mid   (w_fm),
        .o_valid (w_dv),
        .o_mid   (w_dm)
    );

    ssph_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (w_dv),
        .i_mid      (w_dm),
        .i_cfg      (r_cfg),
        .o_valid    (o_valid),
        .o_hit      (o_hit),
        .o_hit_time (o_hit_time),
        .o_contact  (w_pt)
    );

    assign o_contact_x = w_pt[0];
    assign o_contact_y = w_pt[1];
    assign o_contact_z = w_pt[2];

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_hit_time == 17'd0 && o_contact_x == 32'sd0
            && o_contact_y == 32'sd0 && o_contact_z == 32'sd0))
        else $error("miss result with nonzero fields");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hit_time <= 17'd65536))
        else $error("hit time above 1.0");

    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_hit) && $stable(o_hit_time)
            && $stable(o_contact_x) && $stable(o_contact_y) && $stable(o_contact_z)))
        else $error("result changed under stall");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without output backpressure");

endmodule

@@ design/ssph_front.sv @@
// ----------------------------------------------------------------------------
// ssph_front
// Three stages: dot products, signed distances, hit tests and divider setup.
// ----------------------------------------------------------------------------
module ssph_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  ssph_pkg::t_item i_item,
    input  ssph_pkg::t_cfg  i_cfg,
    output logic           o_valid,
    output ssph_pkg::t_mid  o_mid
);
    import ssph_pkg::*;

    logic              r_v1, r_v2, r_v3;
    t_item             r_it1, r_it2;
    logic signed [47:0] r_ns [3];
    logic signed [47:0] r_ne [3];
    logic signed [DW-1:0] r_dfm, r_dto, r_r30;
    t_mid              r_mid;

    logic signed [DW-1:0] n_dfm, n_dto, n_off;
    logic signed [DW-1:0] n_num;
    logic signed [DW:0]   n_den;
    t_mid                 n_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // stage 1: normal times point
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_it1 <= i_item;
            for (int i = 0; i < 3; i++) begin
                r_ns[i] <= $signed(i_cfg.n[i]) * $signed(i_item.s[i]);
                r_ne[i] <= $signed(i_cfg.n[i]) * $signed(i_item.e[i]);
            end
        end
    end

    // stage 2: distances at Q.30
    always_comb begin
        n_off = {{6{i_cfg.off[31]}}, i_cfg.off, 14'b0};
        n_dfm = DW'(r_ns[0]) + DW'(r_ns[1]) + DW'(r_ns[2]) + n_off;
        n_dto = DW'(r_ne[0]) + DW'(r_ne[1]) + DW'(r_ne[2]) + n_off;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_it2 <= r_it1;
            r_dfm <= n_dfm;
            r_dto <= n_dto;
            r_r30 <= $signed({7'b0, r_it1.r, 14'b0});
        end
    end

    // stage 3: tests, divider operands, touch product
    always_comb begin
        n_num       = r_dfm - r_r30;
        n_den       = (DW+1)'(r_dfm) - (DW+1)'(r_dto);
        n_mid.item  = r_it2;
        n_mid.hit   = (r_dto < r_dfm) && (r_dfm > 0) && (r_dto <= r_r30);
        n_mid.touch = (r_dfm <= r_r30);
        n_mid.rem   = QW'($unsigned(n_num));
        n_mid.den   = QW'($unsigned(n_den));
        n_mid.clamp = n_mid.rem >= n_mid.den;
        n_mid.q     = '0;
        for (int i = 0; i < 3; i++)
            n_mid.tprod[i] = $signed(i_cfg.n[i]) * r_dfm;
    end

    always_ff @(posedge i_clk) begin
        if (i_en)
            r_mid <= n_mid;
    end

    assign o_valid = r_v3;
    assign o_mid   = r_mid;

endmodule

@@ design/ssph_divider.sv @@
// ----------------------------------------------------------------------------
// ssph_divider
// Restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module ssph_divider (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  ssph_pkg::t_mid i_mid,
    output logic          o_valid,
    output ssph_pkg::t_mid o_mid
);
    import ssph_pkg::*;

    logic r_v [TBITS];
    t_mid r_m [TBITS];

    for (genvar k = 0; k < TBITS; k++) begin : g_step
        t_mid           w_in;
        t_mid           n_m;
        logic           w_vin;
        logic [QW-1:0]  w_rem2;

        if (k == 0) begin : g_first
            assign w_in  = i_mid;
            assign w_vin = i_valid;
        end else begin : g_next
            assign w_in  = r_m[k-1];
            assign w_vin = r_v[k-1];
        end

        always_comb begin
            n_m    = w_in;
            w_rem2 = {w_in.rem[QW-2:0], 1'b0};
            if (w_rem2 >= w_in.den) begin
                n_m.rem = w_rem2 - w_in.den;
                n_m.q   = {w_in.q[TBITS-2:0], 1'b1};
            end else begin
                n_m.rem = w_rem2;
                n_m.q   = {w_in.q[TBITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n)
                r_v[k] <= 1'b0;
            else if (i_en)
                r_v[k] <= w_vin;
        end

        always_ff @(posedge i_clk) begin
            if (i_en)
                r_m[k] <= n_m;
        end
    end

    assign o_valid = r_v[TBITS-1];
    assign o_mid   = r_m[TBITS-1];

endmodule

@@ design/ssph_back.sv @@
// ----------------------------------------------------------------------------
// ssph_back
// Two stages: interpolation products and rounding, then contact point sums,
// saturation and the output register.
// ----------------------------------------------------------------------------
module ssph_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  ssph_pkg::t_mid      i_mid,
    input  ssph_pkg::t_cfg      i_cfg,
    output logic               o_valid,
    output logic               o_hit,
    output logic [16:0]        o_hit_time,
    output logic [2:0][31:0]   o_contact
);
    import ssph_pkg::*;

    logic               r_v1, r_v2;
    logic               r_hit, r_touch;
    logic [16:0]        r_t;
    logic [2:0][31:0]   r_s;
    logic signed [50:0] r_dp [3];
    logic signed [47:0] r_rp [3];
    logic signed [39:0] r_tr [3];

    logic               r_ohit;
    logic [16:0]        r_otime;
    logic [2:0][31:0]   r_opt;

    logic [16:0]        n_t;
    logic signed [32:0] n_diff [3];
    logic signed [PW-1:0] n_tsum [3];

    logic signed [50:0] n_dsum [3];
    logic signed [47:0] n_rsum [3];
    logic signed [40:0] n_p [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_comb begin
        n_t = i_mid.clamp ? 17'd65536 : {1'b0, i_mid.q};
        for (int i = 0; i < 3; i++) begin
            n_diff[i] = 33'($signed(i_mid.item.e[i])) - 33'($signed(i_mid.item.s[i]));
            n_tsum[i] = $signed(i_mid.tprod[i]) + $signed({{(PW-28){1'b0}}, 1'b1, 27'b0});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit   <= i_mid.hit;
            r_touch <= i_mid.touch;
            r_t     <= n_t;
            r_s     <= i_mid.item.s;
            for (int i = 0; i < 3; i++) begin
                r_dp[i] <= n_diff[i] * $signed({1'b0, n_t});
                r_rp[i] <= $signed(i_cfg.n[i]) * $signed({1'b0, i_mid.item.r});
                r_tr[i] <= n_tsum[i][PW-1:28];
            end
        end
    end

    // round half up, then add up the point wide before saturating
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_dsum[i] = r_dp[i] + 51'sd32768;
            n_rsum[i] = r_rp[i] + 48'sd8192;
            if (r_touch)
                n_p[i] = 41'($signed(r_s[i])) - 41'(r_tr[i]);
            else
                n_p[i] = 41'($signed(r_s[i])) + 41'($signed(n_dsum[i][50:16]))
                       - 41'($signed(n_rsum[i][47:14]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ohit  <= r_hit;
            r_otime <= (r_hit && !r_touch) ? r_t : 17'd0;
            for (int i = 0; i < 3; i++)
                r_opt[i] <= r_hit ? sat32(n_p[i]) : 32'd0;
        end
    end

    assign o_valid    = r_v2;
    assign o_hit      = r_ohit;
    assign o_hit_time = r_otime;
    assign o_contact  = r_opt;

endmodule
